FILE: sv/matrix_inverse_3x3_core_assert.svh
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core assertion macros
// Shared concurrent assertion forms for the 3x3 inverse core.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_CORE_ASSERT_SVH
`define MATRIX_INVERSE_3X3_CORE_ASSERT_SVH

// same-cycle implication
`define MI3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, stage indexes and cofactor tables of the 3x3 inverse core.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DW    = 32;
    localparam int FB    = 16;
    localparam int NE    = 9;
    localparam int SH    = 2 * FB;
    localparam int QB    = DW + 1;
    localparam int CW    = 2 * DW + 1;
    localparam int PW    = 2 * DW;
    localparam int LW    = DW + 1;
    localparam int PLW   = DW + LW + 1;
    localparam int DETW  = 3 * DW + 2;
    localparam int MW    = DETW - 1;
    localparam int NW    = CW + SH;
    localparam int CMPW  = MW + QB;
    localparam int TW    = NE * DW;

    localparam int S_PRD = 0;
    localparam int S_COF = 1;
    localparam int S_DPP = 2;
    localparam int S_DET = 3;
    localparam int S_ABS = 4;
    localparam int S_SET = 5;
    localparam int S_DIV = 6;
    localparam int S_OUT = S_DIV + QB;
    localparam int NS    = S_OUT + 1;

    typedef struct packed {
        logic [NE-1:0] big;
        logic [NE-1:0] neg;
        logic          zero;
    } t_side;

    // cofactor k = x[p]*x[q] - x[s]*x[t], elements in row order
    localparam logic [3:0] CF_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

FILE: sv/matrix_inverse_3x3_core.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// Pipelined 3x3 inverse, adjugate over determinant, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Input stream: one word per matrix, nine signed Q16.16 elements in row
// order on i_s_axis_tdata. Output stream: one word per matrix, the inverse
// in row order on o_m_axis_tdata, flags on o_m_axis_tuser.
// Cofactors and determinant are exact; each quotient is truncated toward
// zero and clipped to 32 bits. A zero determinant gives all zeros with the
// singular flag set.
// Stages: products, cofactors, determinant partial products, determinant,
// magnitudes, divide setup, 33 restoring divide steps with one quotient bit
// per stage, saturation. Throughput: one matrix per cycle unless the full
// pipeline is stalled by the receiver; the nine per-element dividers are
// fully unrolled across stages, one subtract-compare each.
// Reset clears all stage valid bits; no output appears until a new word is
// accepted. When the receiver stalls, each stage holds only if the stage
// after it is full, so empty stages keep filling and o_s_axis_tready drops
// only once the whole pipeline is full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "matrix_inverse_3x3_core_assert.svh"

module matrix_inverse_3x3_core
    import mi3_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [TW-1:0] i_s_axis_tdata,   // a11,a12,a13,a21,a22,a23,a31,a32,a33
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [TW-1:0] o_m_axis_tdata,   // r11,r12,r13,r21,r22,r23,r31,r32,r33
    output logic [1:0]    o_m_axis_tuser    // singular, saturated
);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    logic signed [DW-1:0]   w_x    [NE];
    logic signed [PW-1:0]   r_pa   [NE];
    logic signed [PW-1:0]   r_pb   [NE];
    logic signed [DW-1:0]   r_x0   [3];
    logic signed [CW-1:0]   r_cof1 [NE];
    logic signed [DW-1:0]   r_x1   [3];
    logic signed [PW-1:0]   r_ph   [3];
    logic signed [PLW-1:0]  r_pl   [3];
    logic signed [CW-1:0]   r_cof2 [NE];
    logic signed [DETW-1:0] r_det;
    logic signed [CW-1:0]   r_cof3 [NE];
    logic [MW-1:0]          r_dmag;
    logic                   r_dneg;
    logic                   r_dzero;
    logic [CW-1:0]          r_amag [NE];
    logic [NE-1:0]          r_aneg;
    logic [MW-1:0]          r_rem0 [NE];
    logic [QB-1:0]          r_nlo0 [NE];
    logic [MW-1:0]          r_dm0;
    t_side                  r_sd0;

    logic [MW-1:0] r_rem [QB][NE];
    logic [QB-1:0] r_q   [QB][NE];
    logic [QB-1:0] r_nlo [QB][NE];
    logic [MW-1:0] r_dm  [QB];
    t_side         r_sd  [QB];
    logic [MW-1:0] n_rem [QB][NE];
    logic [QB-1:0] n_q   [QB][NE];
    logic [QB-1:0] n_nlo [QB][NE];

    logic [DW-1:0] r_res [NE];
    logic          r_sing;
    logic          r_sat;
    logic [DW-1:0] n_res [NE];
    logic          n_sat;

    // ---- handshake ----
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        for (int k = 0; k < NS; k++) begin
            if (w_en[k]) begin
                n_vld[k] = (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_en[S_PRD];

    always_comb begin
        for (int l = 0; l < NE; l++) begin
            w_x[l] = $signed(i_s_axis_tdata[l*DW +: DW]);
        end
    end

    // ---- products, cofactors, determinant, magnitudes ----
    always_ff @(posedge i_clk) begin
        if (w_en[S_PRD]) begin
            for (int l = 0; l < NE; l++) begin
                r_pa[l] <= w_x[CF_IDX[l][0]] * w_x[CF_IDX[l][1]];
                r_pb[l] <= w_x[CF_IDX[l][2]] * w_x[CF_IDX[l][3]];
            end
            for (int t = 0; t < 3; t++) begin
                r_x0[t] <= w_x[t];
            end
        end
        if (w_en[S_COF]) begin
            for (int l = 0; l < NE; l++) begin
                r_cof1[l] <= CW'(r_pa[l]) - CW'(r_pb[l]);
            end
            r_x1 <= r_x0;
        end
        if (w_en[S_DPP]) begin
            for (int t = 0; t < 3; t++) begin
                r_ph[t] <= r_x1[t] * $signed(r_cof1[3*t][CW-1:LW]);
                r_pl[t] <= r_x1[t] * $signed({1'b0, r_cof1[3*t][LW-1:0]});
            end
            r_cof2 <= r_cof1;
        end
        if (w_en[S_DET]) begin
            r_det <= (DETW'(r_ph[0]) <<< LW) + DETW'(r_pl[0])
                   + (DETW'(r_ph[1]) <<< LW) + DETW'(r_pl[1])
                   + (DETW'(r_ph[2]) <<< LW) + DETW'(r_pl[2]);
            r_cof3 <= r_cof2;
        end
        if (w_en[S_ABS]) begin
            r_dneg  <= r_det[DETW-1];
            r_dzero <= (r_det == '0);
            r_dmag  <= MW'(r_det[DETW-1] ? -r_det : r_det);
            for (int l = 0; l < NE; l++) begin
                r_aneg[l] <= r_cof3[l][CW-1];
                r_amag[l] <= CW'(r_cof3[l][CW-1] ? -r_cof3[l] : r_cof3[l]);
            end
        end
    end

    // ---- divide setup: dividend is |adj| << SH ----
    always_ff @(posedge i_clk) begin
        if (w_en[S_SET]) begin
            for (int l = 0; l < NE; l++) begin
                r_sd0.big[l] <= (CMPW'({r_amag[l], {SH{1'b0}}}) >= (CMPW'(r_dmag) << QB));
                r_sd0.neg[l] <= r_aneg[l] ^ r_dneg;
                r_rem0[l]    <= MW'({r_amag[l], {SH{1'b0}}} >> QB);
                r_nlo0[l]    <= QB'({r_amag[l], {SH{1'b0}}});
            end
            r_sd0.zero <= r_dzero;
            r_dm0      <= r_dmag;
        end
    end

    // ---- restoring divide, one quotient bit per stage ----
    always_comb begin
        logic [MW:0]   tr;
        logic [MW-1:0] prem;
        logic [QB-1:0] pq;
        logic [QB-1:0] pnlo;
        logic [MW-1:0] pdm;
        for (int j = 0; j < QB; j++) begin
            for (int l = 0; l < NE; l++) begin
                if (j == 0) begin
                    prem = r_rem0[l];
                    pq   = '0;
                    pnlo = r_nlo0[l];
                    pdm  = r_dm0;
                end else begin
                    prem = r_rem[(j == 0) ? 0 : j - 1][l];
                    pq   = r_q[(j == 0) ? 0 : j - 1][l];
                    pnlo = r_nlo[(j == 0) ? 0 : j - 1][l];
                    pdm  = r_dm[(j == 0) ? 0 : j - 1];
                end
                tr = {prem, pnlo[QB-1]};
                if (tr >= {1'b0, pdm}) begin
                    n_rem[j][l] = MW'(tr - {1'b0, pdm});
                    n_q[j][l]   = {pq[QB-2:0], 1'b1};
                end else begin
                    n_rem[j][l] = MW'(tr);
                    n_q[j][l]   = {pq[QB-2:0], 1'b0};
                end
                n_nlo[j][l] = pnlo << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QB; j++) begin
            if (w_en[S_DIV+j]) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_nlo[j] <= n_nlo[j];
                r_dm[j]  <= (j == 0) ? r_dm0 : r_dm[(j == 0) ? 0 : j - 1];
                r_sd[j]  <= (j == 0) ? r_sd0 : r_sd[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // ---- saturation and output ----
    always_comb begin
        logic [QB-1:0] q;
        logic          neg;
        logic          over;
        n_sat = 1'b0;
        for (int l = 0; l < NE; l++) begin
            q    = r_q[QB-1][l];
            neg  = r_sd[QB-1].neg[l];
            over = neg ? (q > (QB'(1) << (DW - 1))) : (q >= (QB'(1) << (DW - 1)));
            if (r_sd[QB-1].zero) begin
                n_res[l] = '0;
            end else if (r_sd[QB-1].big[l] || over) begin
                n_res[l] = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                n_sat    = 1'b1;
            end else begin
                n_res[l] = neg ? (DW'(0) - q[DW-1:0]) : q[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_res  <= n_res;
            r_sing <= r_sd[QB-1].zero;
            r_sat  <= n_sat;
        end
    end

    always_comb begin
        for (int l = 0; l < NE; l++) begin
            o_m_axis_tdata[l*DW +: DW] = r_res[l];
        end
    end

    assign o_m_axis_tvalid = r_vld[S_OUT];
    assign o_m_axis_tuser  = {r_sat, r_sing};

    // ---- checks ----
    `MI3_ASSERT_NOW(a_sing_clean, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[0],
        !o_m_axis_tuser[1] && (o_m_axis_tdata == '0),
        "singular word carries data or saturation")
    `MI3_ASSERT_NOW(a_empty_ready, i_clk, i_rst_n,
        !r_vld[S_OUT], o_s_axis_tready,
        "input stalled while output stage is empty")
    `MI3_ASSERT_NEXT(a_accept_fill, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, r_vld[S_PRD],
        "accepted word did not enter first stage")

endmodule

FILE: test/matrix_inverse_3x3_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core_tb
// Streams 3x3 Q16.16 matrices into the inverse core and checks every output
// word against an exact adjugate-over-determinant predictor, with random
// idling on both sides and a long receiver hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core_tb;
    import mi3_pkg::*;

    typedef struct {
        logic [TW-1:0] elems;
        logic          singular;
        logic          saturated;
    } t_inverse;

    // expected inverse of one matrix word, from exact adjugate and determinant
    function automatic t_inverse predict_inverse(logic [TW-1:0] m);
        logic signed [255:0] x [NE];
        logic signed [255:0] adj [NE];
        logic signed [255:0] det, quo;
        logic signed [255:0] hi, lo;
        t_inverse r;
        hi = (256'sd1 <<< (DW - 1)) - 1;
        lo = -(256'sd1 <<< (DW - 1));
        for (int k = 0; k < NE; k++) x[k] = $signed(m[k*DW +: DW]);
        for (int k = 0; k < NE; k++)
            adj[k] = x[CF_IDX[k][0]] * x[CF_IDX[k][1]] - x[CF_IDX[k][2]] * x[CF_IDX[k][3]];
        det = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
        r.elems = '0;
        r.singular = (det == 0);
        r.saturated = 1'b0;
        if (!r.singular) begin
            for (int k = 0; k < NE; k++) begin
                quo = (adj[k] <<< SH) / det;
                if (quo > hi) begin
                    quo = hi;
                    r.saturated = 1'b1;
                end else if (quo < lo) begin
                    quo = lo;
                    r.saturated = 1'b1;
                end
                r.elems[k*DW +: DW] = quo[DW-1:0];
            end
        end
        return r;
    endfunction

    class inverse_scoreboard;
        t_inverse pending[$];
        int errors = 0;

        function void note_matrix(logic [TW-1:0] m);
            pending.push_back(predict_inverse(m));
        endfunction

        function void check_word(logic [TW-1:0] d, logic [1:0] u);
            t_inverse e;
            if (pending.size() == 0) begin
                $error("unexpected output word");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < NE; k++)
                if (d[k*DW +: DW] !== e.elems[k*DW +: DW]) begin
                    $error("r%0d%0d expected %h actual %h", k / 3 + 1, k % 3 + 1,
                           e.elems[k*DW +: DW], d[k*DW +: DW]);
                    errors++;
                end
            if (u[0] !== e.singular) begin
                $error("singular expected %b actual %b", e.singular, u[0]);
                errors++;
            end
            if (u[1] !== e.saturated) begin
                $error("saturated expected %b actual %b", e.saturated, u[1]);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [TW-1:0] i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [TW-1:0] o_m_axis_tdata;
    logic [1:0]    o_m_axis_tuser;

    inverse_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    int  holdoff = 0;

    matrix_inverse_3x3_core DUT (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tdata, o_m_axis_tuser);
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_matrix(i_s_axis_tdata);
    end

    // receiver: random stall, plus a long hold-off when armed
    always @(posedge i_clk) begin
        if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [DW-1:0] rand_elem();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
            4: return $signed($urandom_range(65535)) - 32768;
            5: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_matrix(logic [TW-1:0] m);
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= m;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    function automatic logic [TW-1:0] diag(logic [DW-1:0] a, b, c);
        logic [TW-1:0] m;
        m = '0;
        m[0*DW +: DW] = a;
        m[4*DW +: DW] = b;
        m[8*DW +: DW] = c;
        return m;
    endfunction

    task automatic send_random(int n);
        logic [TW-1:0] m;
        for (int j = 0; j < n; j++) begin
            for (int k = 0; k < NE; k++) m[k*DW +: DW] = rand_elem();
            if ($urandom_range(9) == 0) m[3*DW +: 3*DW] = m[0 +: 3*DW];
            send_matrix(m);
        end
    endtask

    initial begin
        logic [TW-1:0] m;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000));
        send_matrix('0);
        send_matrix({TW{1'b1}});
        send_matrix(diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'hffff_ffff, 32'h0001_0000, 32'h0001_0000));
        send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_matrix(diag(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001));
        send_matrix({TW/DW{32'h8000_0000}});
        send_matrix({TW/DW{32'h7fff_ffff}});
        send_matrix({TW/DW{32'h5555_aaaa}});
        for (int k = 0; k < NE; k++) m[k*DW +: DW] = (k % 4 == 0) ? 32'h0 : 32'h0001_0000;
        send_matrix(m);
        for (int k = 0; k < NE; k++) m[k*DW +: DW] = (k + 1) << 16;
        send_matrix(m);

        send_idle = 29;
        recv_idle = 68;
        send_random(200);
        send_idle = 68;
        recv_idle = 29;
        send_random(200);
        send_idle = 0;
        recv_idle = 0;
        holdoff = 150;
        send_random(100);
        send_random(150);

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

endmodule
